// ----- sv/fnpll_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fnpll_pkg
// Types, widths and constant tables shared by the fractional-N PLL tuning
// calculator.
// ----------------------------------------------------------------------------
package fnpll_pkg;

    localparam int FREQ_W     = 22;
    localparam int XTAL_W     = 16;
    localparam int VCO_W      = 26;   // freq shifted left by at most 4
    localparam int SCALED_W   = 27;   // VCO shifted by the reference bit
    localparam int INT_W      = 9;
    localparam int FRAC_W     = 18;
    localparam int DIVIDEND_W = SCALED_W + FRAC_W;
    localparam int F3_W       = 24;   // 3 * freq
    localparam int CUT_N      = 32;
    localparam int BAND_N     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    // Long division is spread over the pipeline: STEPS_PER_STAGE quotient
    // bits are resolved in each divider stage.
    localparam int DIV_STAGES      = 9;
    localparam int STEPS_PER_STAGE = DIVIDEND_W / DIV_STAGES;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_XTAL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_DIV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH  = 3'd4;

    // Post-divider codes.
    localparam logic [1:0] PDIV_DIV16 = 2'd3;
    localparam logic [1:0] PDIV_DIV8  = 2'd2;
    localparam logic [1:0] PDIV_DIV4  = 2'd1;
    localparam logic [1:0] PDIV_DIV2  = 2'd0;

    localparam logic [INT_W-1:0] INT_MAX = '1;
    localparam logic [2:0]       ICP_OOR = 3'd7;
    localparam logic [22:0]      VCO_TOP_KHZ = 23'd4760000;

    localparam logic [22:0] BAND_TOP [BAND_N] = '{
        23'd2472000, 23'd2700000, 23'd3021000, 23'd3387000,
        23'd3845000, 23'd4394000, 23'd4760000
    };
    localparam logic [2:0] BAND_ICP [BAND_N] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7
    };

    localparam logic [12:0] CUTOFF_TAB [CUT_N] = '{
        13'd6796, 13'd5828, 13'd4778, 13'd4118, 13'd3513, 13'd3136, 13'd2794, 13'd2562,
        13'd2331, 13'd2169, 13'd2006, 13'd1890, 13'd1771, 13'd1680, 13'd1586, 13'd1514,
        13'd1433, 13'd1374, 13'd1310, 13'd1262, 13'd1208, 13'd1167, 13'd1122, 13'd1087,
        13'd1049, 13'd1018, 13'd983,  13'd956,  13'd926,  13'd902,  13'd875,  13'd854
    };

    // floor(3f/1000) <= c holds exactly when 3f <= 1000c + 999.
    function automatic logic [F3_W-1:0] cut_limit(input int idx);
        int lim;
        lim = int'(CUTOFF_TAB[idx]) * 1000 + 999;
        return F3_W'(lim);
    endfunction

    typedef struct packed {
        logic       tuner;
        logic [1:0] code;
        logic [2:0] icp;
        logic       vco_oor;
        logic [4:0] cut;
        logic       cut_oor;
        logic       ovf;
    } t_side;

    typedef struct packed {
        t_side                   side;
        logic [XTAL_W-1:0]       rem;
        logic [DIVIDEND_W-1:0]   w;     // dividend bits shift out, quotient bits in
    } t_div;

    typedef struct packed {
        logic              tuner;
        logic [FREQ_W-1:0] freq;
        logic [1:0]        code;
        logic [CUT_N-1:0]  cut_hit;
    } t_front;

endpackage
`default_nettype wire

// ----- sv/fractional_n_pll_tuning_calc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fractional_n_pll_tuning_calc_core
// Computes post-divider code, integer/fractional divider, charge-pump current
// and HF cutoff code for a requested LO frequency.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while m_axis is ready; the 45-step long
// division by the crystal runs as a 9-stage pipeline of 5 compare-subtract
// steps each. Each stage holds its item while the next stage is full and
// cannot advance, so stalls lose nothing.
// Reset (synchronous, active low) empties the pipeline and loads the default
// crystal, reference bit and post-divider thresholds.
module fractional_n_pll_tuning_calc_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [21:0] i_cfg_data,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [21:0] freq_khz, [23:22] zero
    input  wire logic        s_axis_tuser,   // [0] tuner_index
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [8:0] pll_int, [26:9] pll_frac, [28:27] post_div_code, [31:29] charge_pump,
    // [36:32] hf_cutoff_code, [37] vco_out_of_range, [38] cutoff_out_of_range,
    // [39] int_overflow
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tuser    // [0] tuner_out
);

    // ---------------------------------------------------------------- config
    logic [fnpll_pkg::XTAL_W-1:0] r_xtal;
    logic                         r_ref_div;
    logic [fnpll_pkg::FREQ_W-1:0] r_thr_low;
    logic [fnpll_pkg::FREQ_W-1:0] r_thr_mid;
    logic [fnpll_pkg::FREQ_W-1:0] r_thr_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xtal     <= 16'd30000;
            r_ref_div  <= 1'b1;
            r_thr_low  <= 22'd306000;
            r_thr_mid  <= 22'd612000;
            r_thr_high <= 22'd1225000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fnpll_pkg::CFG_XTAL:     r_xtal     <= i_cfg_data[15:0];
                fnpll_pkg::CFG_REF_DIV:  r_ref_div  <= i_cfg_data[0];
                fnpll_pkg::CFG_THR_LOW:  r_thr_low  <= i_cfg_data;
                fnpll_pkg::CFG_THR_MID:  r_thr_mid  <= i_cfg_data;
                fnpll_pkg::CFG_THR_HIGH: r_thr_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    localparam int LAST = fnpll_pkg::DIV_STAGES;

    logic                r_front_vld;
    fnpll_pkg::t_front   r_front;
    fnpll_pkg::t_front   n_front;
    logic                front_rdy;

    logic                r_dvld [LAST+1];
    fnpll_pkg::t_div     r_div  [LAST+1];
    fnpll_pkg::t_div     n_div  [LAST+1];
    fnpll_pkg::t_div     n_vco;
    logic                drdy   [LAST+1];

    always_comb begin
        drdy[LAST] = !r_dvld[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            drdy[k] = !r_dvld[k] || drdy[k+1];
        end
    end

    assign front_rdy     = !r_front_vld || drdy[0];
    assign s_axis_tready = front_rdy;

    // ------------------------------------------- stage 1: code and cutoff scan
    logic [fnpll_pkg::F3_W-1:0] f3;

    always_comb begin
        n_front.tuner = s_axis_tuser;
        n_front.freq  = s_axis_tdata[fnpll_pkg::FREQ_W-1:0];
        // Thresholds are tested in order even if they are not ascending.
        if (n_front.freq <= r_thr_low) begin
            n_front.code = fnpll_pkg::PDIV_DIV16;
        end else if (n_front.freq <= r_thr_mid) begin
            n_front.code = fnpll_pkg::PDIV_DIV8;
        end else if (n_front.freq <= r_thr_high) begin
            n_front.code = fnpll_pkg::PDIV_DIV4;
        end else begin
            n_front.code = fnpll_pkg::PDIV_DIV2;
        end
        f3 = {2'b00, n_front.freq} + {1'b0, n_front.freq, 1'b0};
        for (int i = 0; i < fnpll_pkg::CUT_N; i++) begin
            n_front.cut_hit[i] = (f3 <= fnpll_pkg::cut_limit(i));
        end
    end

    // ------------------------------- stage 2: VCO, bands, cutoff, overflow
    logic [fnpll_pkg::VCO_W-1:0]    vco;
    logic [fnpll_pkg::SCALED_W-1:0] scaled;
    logic [5:0]                     cut_cnt;

    always_comb begin
        vco    = fnpll_pkg::VCO_W'({4'd0, r_front.freq} << (r_front.code + 3'd1));
        scaled = {1'b0, vco} << r_ref_div;

        n_vco.side.tuner = r_front.tuner;
        n_vco.side.code  = r_front.code;

        // A zero crystal also lands here, since the compare limit is zero.
        n_vco.side.ovf = (scaled >= {2'b00, r_xtal, 9'd0});

        n_vco.side.vco_oor = (vco > {3'd0, fnpll_pkg::VCO_TOP_KHZ});
        n_vco.side.icp     = fnpll_pkg::ICP_OOR;
        if (!n_vco.side.vco_oor) begin
            for (int i = fnpll_pkg::BAND_N - 1; i >= 0; i--) begin
                if (vco <= {3'd0, fnpll_pkg::BAND_TOP[i]}) begin
                    n_vco.side.icp = fnpll_pkg::BAND_ICP[i];
                end
            end
        end

        // The scan stops at the first table entry that the value exceeds.
        cut_cnt = 6'd32;
        for (int i = fnpll_pkg::CUT_N - 1; i >= 0; i--) begin
            if (!r_front.cut_hit[i]) begin
                cut_cnt = 6'(i);
            end
        end
        if (cut_cnt == 6'd0) begin
            n_vco.side.cut     = 5'd0;
            n_vco.side.cut_oor = 1'b1;
        end else begin
            n_vco.side.cut     = 5'(cut_cnt - 6'd1);
            n_vco.side.cut_oor = (cut_cnt == 6'd32);
        end

        n_vco.rem = '0;
        n_vco.w   = {scaled, {fnpll_pkg::FRAC_W{1'b0}}};
    end

    // ------------------------------------------- stages 3..11: long division
    function automatic fnpll_pkg::t_div div_step(input fnpll_pkg::t_div d,
                                                 input logic [fnpll_pkg::XTAL_W-1:0] xtal);
        fnpll_pkg::t_div            o;
        logic [fnpll_pkg::XTAL_W:0] part;
        o    = d;
        part = {d.rem, d.w[fnpll_pkg::DIVIDEND_W-1]};
        if (part >= {1'b0, xtal}) begin
            o.rem = fnpll_pkg::XTAL_W'(part - {1'b0, xtal});
            o.w   = {d.w[fnpll_pkg::DIVIDEND_W-2:0], 1'b1};
        end else begin
            o.rem = part[fnpll_pkg::XTAL_W-1:0];
            o.w   = {d.w[fnpll_pkg::DIVIDEND_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_div[0] = n_vco;
        for (int k = 1; k <= LAST; k++) begin
            n_div[k] = r_div[k-1];
            for (int s = 0; s < fnpll_pkg::STEPS_PER_STAGE; s++) begin
                n_div[k] = div_step(n_div[k], r_xtal);
            end
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= 1'b0;
            for (int k = 0; k <= LAST; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else begin
            if (front_rdy) begin
                r_front_vld <= s_axis_tvalid;
            end
            if (drdy[0]) begin
                r_dvld[0] <= r_front_vld;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (drdy[k]) begin
                    r_dvld[k] <= r_dvld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && front_rdy) begin
            r_front <= n_front;
        end
        if (r_front_vld && drdy[0]) begin
            r_div[0] <= n_div[0];
        end
        for (int k = 1; k <= LAST; k++) begin
            if (r_dvld[k-1] && drdy[k]) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // --------------------------------------------------------------- output
    logic [fnpll_pkg::INT_W-1:0]  pll_int;
    logic [fnpll_pkg::FRAC_W-1:0] pll_frac;

    always_comb begin
        pll_int  = r_div[LAST].side.ovf ? fnpll_pkg::INT_MAX
                 : r_div[LAST].w[fnpll_pkg::FRAC_W +: fnpll_pkg::INT_W];
        pll_frac = (r_xtal == '0) ? '0 : r_div[LAST].w[fnpll_pkg::FRAC_W-1:0];
    end

    assign m_axis_tvalid = r_dvld[LAST];
    assign m_axis_tuser  = r_div[LAST].side.tuner;
    assign m_axis_tdata  = {r_div[LAST].side.ovf,
                            r_div[LAST].side.cut_oor,
                            r_div[LAST].side.vco_oor,
                            r_div[LAST].side.cut,
                            r_div[LAST].side.icp,
                            r_div[LAST].side.code,
                            pll_frac,
                            pll_int};

endmodule
`default_nettype wire
